@@ rtl/assert_macros.svh @@
// Assertion macros shared by the placement block's RTL files.
// Each macro samples on the rising edge of aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define MBEP_ASSERT_NOW(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define MBEP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define MBEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mbep_pkg.sv @@
// Package for the multi-bin expert placement block: widths, codes, state and control types.
// Used by mbep_ctrl, mbep_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package mbep_pkg;

    localparam int MAX_LANES_DEF   = 3;
    localparam int NUM_LAYERS_DEF  = 64;
    localparam int NUM_EXPERTS_DEF = 256;

    localparam int LAYER_W     = 6;
    localparam int EXPERT_W    = 8;
    localparam int BYTES_W     = 32;
    localparam int COST_W      = 33;
    localparam int BUDGET_W    = 40;
    localparam int COUNT_W     = 9;
    localparam int LANE_OUT_W  = 2;
    localparam int LANE_CNT_W  = 2;
    localparam int STATUS_W    = 2;
    localparam int BUDGET_REGS = 3;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET2    = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    typedef enum logic [STATUS_W-1:0] {
        STAT_PLACED    = 2'd0,
        STAT_DUPLICATE = 2'd1,
        STAT_NO_FIT    = 2'd2,
        STAT_CLEARED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic decide;
        logic sweep;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_clear;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/multi_bin_expert_placement.sv @@
// Flow: an accepted request goes through memory read, lane evaluation, commit and hand-off in
// turn; no new request is taken until its result is loaded into the output register and m_tvalid,
// which waits while the output is not free. A clear sweeps one memory row a cycle over all rows.
// Reset: synchronous, active low; afterwards a clearing pass over all NUM_LAYERS rows (64 by
// default) runs with s_tready low, while configuration writes are taken.
`timescale 1ns / 1ps

module multi_bin_expert_placement import mbep_pkg::*; #(
    parameter int MAX_LANES   = MAX_LANES_DEF,
    parameter int NUM_LAYERS  = NUM_LAYERS_DEF,
    parameter int NUM_EXPERTS = NUM_EXPERTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,   // func
    input  logic [S_TDATA_W-1:0]  s_tdata,   // layer[5:0], expert[13:6], expert_bytes[45:14]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [STATUS_W-1:0]   m_tuser,   // status
    output logic [M_TDATA_W-1:0]  m_tdata    // lane[1:0], charged_bytes[34:2], lane_used_after[74:35]
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    mbep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbep_dp #(
        .MAX_LANES   (MAX_LANES),
        .NUM_LAYERS  (NUM_LAYERS),
        .NUM_EXPERTS (NUM_EXPERTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ rtl/mbep_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used by mbep_dp for the placement map and the per-layer lane counts.
`timescale 1ns / 1ps

module mbep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mbep_ctrl.sv @@
// Controller state machine of the placement block: sequences lookup, decision, clear sweep
// and result hand-off. Depends on mbep_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbep_ctrl import mbep_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_INIT_CLEAR: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.req_clear ? ST_CLEAR : ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_RESULT;
            end
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT_CLEAR;
            end
        endcase
    end

    `MBEP_ASSERT_NEXT(a_one_request_in_flight, s_tvalid && s_tready, !s_tready, "request accepted while another is in flight")
    `MBEP_ASSERT_NOW(a_cmd_exclusive, $onehot0({cmd.accept, cmd.lookup, cmd.decide, cmd.sweep, cmd.load_out}), "controller issued overlapping commands")

endmodule

@@ rtl/mbep_dp.sv @@
// Datapath of the placement block: configuration registers, lane usage, placement map and
// lane count memories, lane evaluation and the output register. Depends on mbep_pkg,
// mbep_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbep_dp import mbep_pkg::*; #(
    parameter int MAX_LANES   = MAX_LANES_DEF,
    parameter int NUM_LAYERS  = NUM_LAYERS_DEF,
    parameter int NUM_EXPERTS = NUM_EXPERTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tuser,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [STATUS_W-1:0]   m_tuser,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            stat
);

    localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int ROW_AW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int EXP_AW = (NUM_EXPERTS > 1) ? $clog2(NUM_EXPERTS) : 1;
    localparam int CROW_W = MAX_LANES * COUNT_W;
    localparam logic [ROW_AW-1:0] SWEEP_LAST = ROW_AW'(NUM_LAYERS - 1);

    // Configuration and plan state.
    logic [LANE_CNT_W-1:0] lane_count_reg;
    logic                  mode_reg;
    logic [BUDGET_W-1:0]   budget_reg [BUDGET_REGS];
    logic [BUDGET_W-1:0]   bin_used_reg [MAX_LANES];
    logic [ROW_AW-1:0]     sweep_cnt_reg;

    // Latched request.
    logic [LAYER_W-1:0]  layer_reg;
    logic [EXPERT_W-1:0] expert_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic                range_ok_reg;

    // Lane evaluation.
    logic                                  placed_hit_reg;
    logic                                  placed_hit_next;
    logic [MAX_LANES-1:0]                  fit_reg;
    logic [MAX_LANES-1:0]                  fit_next;
    logic [MAX_LANES-1:0]                  fresh_reg;
    logic [MAX_LANES-1:0]                  fresh_next;
    logic [MAX_LANES-1:0][MAX_LANES-1:0]   before_reg;
    logic [MAX_LANES-1:0][MAX_LANES-1:0]   before_next;

    // Pending result and output register.
    status_t             res_status_reg;
    status_t             res_status_next;
    logic [LANE_W-1:0]   res_lane_reg;
    logic [COST_W-1:0]   res_charged_reg;
    logic [BUDGET_W-1:0] res_used_reg;
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [LANE_OUT_W-1:0] m_lane_reg;
    logic [COST_W-1:0]   m_charged_reg;
    logic [BUDGET_W-1:0] m_used_reg;

    // Memories.
    logic [NUM_EXPERTS-1:0] prow_rdata;
    logic [NUM_EXPERTS-1:0] prow_wdata;
    logic [CROW_W-1:0]      crow_rdata;
    logic [CROW_W-1:0]      crow_wdata;
    logic                   ram_we;
    logic [ROW_AW-1:0]      ram_waddr;
    logic [ROW_AW-1:0]      ram_raddr;

    // Input fields.
    logic [LAYER_W-1:0]  in_layer;
    logic [EXPERT_W-1:0] in_expert;
    logic [BYTES_W-1:0]  in_bytes;
    logic                in_range;

    // Evaluation and decision signals.
    logic [LANE_CNT_W-1:0] lane_lim;
    logic [COUNT_W-1:0]    lane_cnt [MAX_LANES];
    logic [BUDGET_W-1:0]   lane_budget [MAX_LANES];
    logic [COST_W-1:0]     lane_cost [MAX_LANES];
    logic [MAX_LANES-1:0]  choose;
    logic                  any_fit;
    logic                  do_place;
    logic [LANE_W-1:0]     ch;
    logic [COST_W-1:0]     ch_cost;
    logic [BUDGET_W-1:0]   used_sum;
    logic [COUNT_W-1:0]    cnt_ch;
    logic [COUNT_W-1:0]    cnt_inc;
    logic [EXP_AW-1:0]     expert_idx;

    assign in_layer  = s_tdata[LAYER_W-1:0];
    assign in_expert = s_tdata[LAYER_W +: EXPERT_W];
    assign in_bytes  = s_tdata[LAYER_W + EXPERT_W +: BYTES_W];
    assign in_range  = (int'(in_layer) < NUM_LAYERS) && (int'(in_expert) < NUM_EXPERTS);
    assign ram_raddr = ROW_AW'(in_layer);
    assign expert_idx = EXP_AW'(expert_reg);

    mbep_ram #(
        .WIDTH (NUM_EXPERTS),
        .DEPTH (NUM_LAYERS)
    ) u_placed_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (prow_wdata),
        .re    (cmd.accept),
        .raddr (ram_raddr),
        .rdata (prow_rdata)
    );

    mbep_ram #(
        .WIDTH (CROW_W),
        .DEPTH (NUM_LAYERS)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (crow_wdata),
        .re    (cmd.accept),
        .raddr (ram_raddr),
        .rdata (crow_rdata)
    );

    // Lane evaluation: fit test per lane, the pairwise placement order and the duplicate check.
    always_comb begin
        lane_lim = (lane_count_reg == '0) ? LANE_CNT_W'(1) : lane_count_reg;
        for (int a = 0; a < MAX_LANES; a++) begin
            lane_cnt[a] = crow_rdata[a*COUNT_W +: COUNT_W];
            if (a == 0) begin
                lane_budget[a] = budget_reg[0];
            end else if (a == 1) begin
                lane_budget[a] = budget_reg[1];
            end else if (a == 2) begin
                lane_budget[a] = budget_reg[2];
            end else begin
                lane_budget[a] = '0;
            end
            fresh_next[a] = (lane_cnt[a] == '0);
            lane_cost[a]  = fresh_next[a] ? {bytes_reg, 1'b0} : {1'b0, bytes_reg};
            fit_next[a]   = (a < int'(lane_lim))
                         && (BUDGET_W'(lane_cost[a]) <= lane_budget[a])
                         && (bin_used_reg[a] <= lane_budget[a] - BUDGET_W'(lane_cost[a]));
        end
        for (int a = 0; a < MAX_LANES; a++) begin
            for (int b = 0; b < MAX_LANES; b++) begin
                if (mode_reg) begin
                    before_next[a][b] = (lane_cnt[a] < lane_cnt[b])
                        || ((lane_cnt[a] == lane_cnt[b])
                            && ((bin_used_reg[a] < bin_used_reg[b])
                                || ((bin_used_reg[a] == bin_used_reg[b]) && (a < b))));
                end else begin
                    before_next[a][b] = (a < b);
                end
            end
        end
        placed_hit_next = prow_rdata[expert_idx];
    end

    // Decision: the fitting lane that no other fitting lane goes before, the result status and the memory writes.
    always_comb begin
        choose = '0;
        ch     = '0;
        for (int a = 0; a < MAX_LANES; a++) begin
            choose[a] = fit_reg[a];
            for (int b = 0; b < MAX_LANES; b++) begin
                if ((b != a) && fit_reg[b] && before_reg[b][a]) begin
                    choose[a] = 1'b0;
                end
            end
            if (choose[a]) begin
                ch = LANE_W'(a);
            end
        end
        any_fit  = |fit_reg;
        do_place = range_ok_reg && !placed_hit_reg && any_fit;
        ch_cost  = fresh_reg[ch] ? {bytes_reg, 1'b0} : {1'b0, bytes_reg};
        used_sum = bin_used_reg[ch] + BUDGET_W'(ch_cost);
        cnt_ch   = crow_rdata[ch*COUNT_W +: COUNT_W];
        cnt_inc  = (cnt_ch < COUNT_MAX) ? cnt_ch + COUNT_W'(1) : cnt_ch;

        if (!range_ok_reg) begin
            res_status_next = STAT_NO_FIT;
        end else if (placed_hit_reg) begin
            res_status_next = STAT_DUPLICATE;
        end else if (any_fit) begin
            res_status_next = STAT_PLACED;
        end else begin
            res_status_next = STAT_NO_FIT;
        end

        prow_wdata = prow_rdata;
        crow_wdata = crow_rdata;
        prow_wdata[expert_idx] = 1'b1;
        crow_wdata[ch*COUNT_W +: COUNT_W] = cnt_inc;
        ram_we    = cmd.decide && do_place;
        ram_waddr = ROW_AW'(layer_reg);
        if (cmd.sweep) begin
            ram_we     = 1'b1;
            ram_waddr  = sweep_cnt_reg;
            prow_wdata = '0;
            crow_wdata = '0;
        end
    end

    // Control state: configuration, lane usage, sweep counter, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_count_reg <= LANE_CNT_W'(1);
            mode_reg       <= 1'b0;
            for (int r = 0; r < BUDGET_REGS; r++) begin
                budget_reg[r] <= '0;
            end
            for (int a = 0; a < MAX_LANES; a++) begin
                bin_used_reg[a] <= '0;
            end
            sweep_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_LANE_COUNT: lane_count_reg <= cfg_wdata[LANE_CNT_W-1:0];
                    CFG_MODE:       mode_reg       <= cfg_wdata[0];
                    CFG_BUDGET0:    budget_reg[0]  <= cfg_wdata[BUDGET_W-1:0];
                    CFG_BUDGET1:    budget_reg[1]  <= cfg_wdata[BUDGET_W-1:0];
                    CFG_BUDGET2:    budget_reg[2]  <= cfg_wdata[BUDGET_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.sweep) begin
                for (int a = 0; a < MAX_LANES; a++) begin
                    bin_used_reg[a] <= '0;
                end
                sweep_cnt_reg <= stat.sweep_last ? '0 : sweep_cnt_reg + ROW_AW'(1);
            end else if (cmd.decide && do_place) begin
                bin_used_reg[ch] <= used_sum;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            layer_reg    <= in_layer;
            expert_reg   <= in_expert;
            bytes_reg    <= in_bytes;
            range_ok_reg <= in_range;
            if (s_tuser) begin
                res_status_reg  <= STAT_CLEARED;
                res_lane_reg    <= '0;
                res_charged_reg <= '0;
                res_used_reg    <= '0;
            end
        end
        if (cmd.lookup) begin
            placed_hit_reg <= placed_hit_next;
            fit_reg        <= fit_next;
            fresh_reg      <= fresh_next;
            before_reg     <= before_next;
        end
        if (cmd.decide) begin
            res_status_reg  <= res_status_next;
            res_lane_reg    <= do_place ? ch : '0;
            res_charged_reg <= do_place ? ch_cost : '0;
            res_used_reg    <= do_place ? used_sum : '0;
        end
        if (cmd.load_out) begin
            m_status_reg  <= res_status_reg;
            m_lane_reg    <= LANE_OUT_W'(res_lane_reg);
            m_charged_reg <= res_charged_reg;
            m_used_reg    <= res_used_reg;
        end
    end

    assign stat.req_clear  = s_tuser;
    assign stat.sweep_last = (sweep_cnt_reg == SWEEP_LAST);
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {(M_TDATA_W - LANE_OUT_W - COST_W - BUDGET_W)'(0),
                       m_used_reg, m_charged_reg, m_lane_reg};

    `MBEP_ASSERT_SAME(a_single_lane_chosen, cmd.decide, $onehot0(choose), "more than one lane chosen")
    `MBEP_ASSERT_NEXT(a_used_matches_lane, cmd.decide && do_place, res_used_reg == bin_used_reg[res_lane_reg], "reported usage differs from lane usage")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for multi_bin_expert_placement: directed rows, then phases of
// random placement requests under changing lane settings, checked by an in-bench planner.
// Depends on mbep_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
    import mbep_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int PHASES = 12;
    localparam int CALM_FROM = 950;
    localparam logic [CFG_DATA_W-1:0] BUDGET_FULL = 40'hFF_FFFF_FFFF;

    typedef struct {
        status_t     status;
        logic [1:0]  lane;
        logic [32:0] charged;
        logic [39:0] used;
    } outcome_t;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_value;
        bit                    func;
        logic [5:0]            layer;
        logic [7:0]            expert;
        logic [31:0]           bytes;
        bit                    typed;
        outcome_t              want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic                  s_tuser;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [STATUS_W-1:0]   m_tuser;
    logic [M_TDATA_W-1:0]  m_tdata;

    multi_bin_expert_placement dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // Planner mirror: settings and plan contents.
    logic [1:0]  cfg_lanes = 2'd1;
    logic        cfg_balanced = 1'b0;
    logic [39:0] lane_budget [3] = '{default: '0};
    logic [39:0] lane_fill [3] = '{default: '0};
    logic [8:0]  layer_share [3][64];
    logic [255:0] placed_pairs [64];

    outcome_t  pending_outcomes [$];
    outcome_t  head;
    stim_row_t opening_rows [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        calm_tail = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void wipe_plan();
        for (int ln = 0; ln < 3; ln++) begin
            lane_fill[ln] = '0;
            for (int ly = 0; ly < 64; ly++) layer_share[ln][ly] = '0;
        end
        for (int ly = 0; ly < 64; ly++) placed_pairs[ly] = '0;
    endfunction

    function automatic outcome_t plan_request(input stim_row_t r);
        outcome_t res;
        int n, i, j, v, ln;
        int order [3];
        bit ahead;
        longint unsigned cost, budget, fill;
        res.status = STAT_NO_FIT;
        res.lane = '0;
        res.charged = '0;
        res.used = '0;
        if (r.func) begin
            wipe_plan();
            res.status = STAT_CLEARED;
            return res;
        end
        if (placed_pairs[r.layer][r.expert]) begin
            res.status = STAT_DUPLICATE;
            return res;
        end
        n = (cfg_lanes == 2'd0) ? 1 : int'(cfg_lanes);
        for (i = 0; i < n; i++) order[i] = i;
        if (cfg_balanced) begin
            // Fewest experts of this layer first, then least used, then lowest index.
            for (i = 1; i < n; i++) begin
                v = order[i];
                j = i;
                ahead = 1'b1;
                while (j > 0 && ahead) begin
                    ln = order[j-1];
                    if (layer_share[v][r.layer] != layer_share[ln][r.layer])
                        ahead = layer_share[v][r.layer] < layer_share[ln][r.layer];
                    else if (lane_fill[v] != lane_fill[ln])
                        ahead = lane_fill[v] < lane_fill[ln];
                    else
                        ahead = v < ln;
                    if (ahead) begin
                        order[j] = ln;
                        j--;
                    end
                end
                order[j] = v;
            end
        end
        for (i = 0; i < n; i++) begin
            ln = order[i];
            cost = r.bytes;
            if (layer_share[ln][r.layer] == '0) cost += r.bytes;
            budget = lane_budget[ln];
            fill = lane_fill[ln];
            if (cost <= budget && fill <= budget - cost) begin
                lane_fill[ln] = 40'(fill + cost);
                if (layer_share[ln][r.layer] != COUNT_MAX) layer_share[ln][r.layer]++;
                placed_pairs[r.layer][r.expert] = 1'b1;
                res.status = STAT_PLACED;
                res.lane = 2'(ln);
                res.charged = 33'(cost);
                res.used = lane_fill[ln];
                return res;
            end
        end
        return res;
    endfunction

    function automatic void step_row(input bit f, input logic [5:0] ly, input logic [7:0] ex,
                                     input logic [31:0] nb);
        stim_row_t r;
        r.is_reg = 1'b0;
        r.reg_idx = '0;
        r.reg_value = '0;
        r.func = f;
        r.layer = ly;
        r.expert = ex;
        r.bytes = nb;
        r.typed = 1'b0;
        opening_rows = {opening_rows, r};
    endfunction

    function automatic void known_row(input bit f, input logic [5:0] ly, input logic [7:0] ex,
                                      input logic [31:0] nb, input status_t st,
                                      input logic [1:0] ln, input logic [32:0] ch,
                                      input logic [39:0] us);
        step_row(f, ly, ex, nb);
        opening_rows[$].typed = 1'b1;
        opening_rows[$].want.status = st;
        opening_rows[$].want.lane = ln;
        opening_rows[$].want.charged = ch;
        opening_rows[$].want.used = us;
    endfunction

    function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
        step_row(1'b0, '0, '0, '0);
        opening_rows[$].is_reg = 1'b1;
        opening_rows[$].reg_idx = idx;
        opening_rows[$].reg_value = value;
    endfunction

    // Called at a falling edge; returns at the next falling edge with the write issued.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_LANE_COUNT: cfg_lanes = value[1:0];
            CFG_MODE:       cfg_balanced = value[0];
            CFG_BUDGET0:    lane_budget[0] = value;
            CFG_BUDGET1:    lane_budget[1] = value;
            CFG_BUDGET2:    lane_budget[2] = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input stim_row_t r);
        int gap;
        outcome_t predicted;
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.func;
        s_tdata <= {2'b00, r.bytes, r.expert, r.layer};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = plan_request(r);
        if (r.typed) predicted = r.want;
        pending_outcomes = {pending_outcomes, predicted};
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with none expected: status %0d", m_tuser);
                mismatches++;
            end else begin
                head = pending_outcomes.pop_front();
                if (m_tuser !== head.status) begin
                    $error("status: expected %0d, actual %0d", head.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[1:0] !== head.lane) begin
                    $error("lane: expected %0d, actual %0d", head.lane, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[34:2] !== head.charged) begin
                    $error("charged_bytes: expected %0d, actual %0d",
                           head.charged, m_tdata[34:2]);
                    mismatches++;
                end
                if (m_tdata[74:35] !== head.used) begin
                    $error("lane_used_after: expected %0d, actual %0d",
                           head.used, m_tdata[74:35]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int sent;
        int kind;
        stim_row_t r;
        logic [CFG_DATA_W-1:0] budget;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        wipe_plan();

        // Reset settings: one lane with no budget, so only zero-size requests fit.
        known_row(1'b0, 6'd0, 8'd0, 32'd0, STAT_PLACED, 2'd0, 33'd0, 40'd0);
        known_row(1'b0, 6'd0, 8'd0, 32'd0, STAT_DUPLICATE, 2'd0, 33'd0, 40'd0);
        known_row(1'b0, 6'd1, 8'd1, 32'd1, STAT_NO_FIT, 2'd0, 33'd0, 40'd0);
        known_row(1'b1, 6'd0, 8'd0, 32'd0, STAT_CLEARED, 2'd0, 33'd0, 40'd0);
        known_row(1'b0, 6'd0, 8'd0, 32'd0, STAT_PLACED, 2'd0, 33'd0, 40'd0);
        // Index order over three lanes: exact fit, dummy overhead, spill to later lanes.
        reg_row(CFG_LANE_COUNT, 40'd3);
        reg_row(CFG_MODE, 40'd0);
        reg_row(CFG_BUDGET0, 40'd100);
        reg_row(CFG_BUDGET1, 40'd1000);
        reg_row(CFG_BUDGET2, BUDGET_FULL);
        known_row(1'b0, 6'd63, 8'd255, 32'd50, STAT_PLACED, 2'd0, 33'd100, 40'd100);
        known_row(1'b0, 6'd63, 8'd254, 32'd0, STAT_PLACED, 2'd0, 33'd0, 40'd100);
        known_row(1'b0, 6'd63, 8'd253, 32'd1, STAT_PLACED, 2'd1, 33'd2, 40'd2);
        known_row(1'b0, 6'd0, 8'd255, 32'hFFFF_FFFF, STAT_PLACED, 2'd2,
                  33'h1_FFFF_FFFE, 40'h1_FFFF_FFFE);
        step_row(1'b0, 6'd1, 8'd0, 32'hFFFF_FFFF);
        step_row(1'b0, 6'd42, 8'd128, 32'h8000_0000);
        // Balanced order: rotate across lanes, then break ties on usage and index.
        reg_row(CFG_MODE, 40'd1);
        reg_row(CFG_BUDGET0, BUDGET_FULL);
        reg_row(CFG_BUDGET1, BUDGET_FULL);
        known_row(1'b1, 6'd0, 8'd0, 32'd0, STAT_CLEARED, 2'd0, 33'd0, 40'd0);
        known_row(1'b0, 6'd5, 8'd0, 32'd10, STAT_PLACED, 2'd0, 33'd20, 40'd20);
        known_row(1'b0, 6'd5, 8'd1, 32'd10, STAT_PLACED, 2'd1, 33'd20, 40'd20);
        known_row(1'b0, 6'd5, 8'd2, 32'd10, STAT_PLACED, 2'd2, 33'd20, 40'd20);
        known_row(1'b0, 6'd5, 8'd3, 32'd10, STAT_PLACED, 2'd0, 33'd10, 40'd30);
        known_row(1'b0, 6'd6, 8'd0, 32'd5, STAT_PLACED, 2'd1, 33'd10, 40'd30);
        reg_row(CFG_LANE_COUNT, 40'd2);
        step_row(1'b0, 6'd6, 8'd1, 32'd5);
        // A lane count of zero behaves as one lane.
        reg_row(CFG_LANE_COUNT, 40'd0);
        step_row(1'b0, 6'd7, 8'd0, 32'd1);
        step_row(1'b0, 6'd7, 8'd1, 32'd1);

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < opening_rows.size(); i++) begin
            if (opening_rows[i].is_reg) begin
                if (i == 0 || !opening_rows[i-1].is_reg) wait_idle();
                write_register(opening_rows[i].reg_idx, opening_rows[i].reg_value);
                if (i + 1 == opening_rows.size() || !opening_rows[i+1].is_reg)
                    cfg_wr_en <= 1'b0;
            end else begin
                send_request(opening_rows[i]);
            end
        end

        sent = 0;
        r.is_reg = 1'b0;
        r.reg_idx = '0;
        r.reg_value = '0;
        r.typed = 1'b0;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            write_register(CFG_LANE_COUNT, 40'(phase % 4));
            write_register(CFG_MODE, (phase < 8) ? 40'((phase / 4) % 2)
                                                 : 40'($urandom_range(0, 1)));
            for (int ln = 0; ln < 3; ln++) begin
                kind = $urandom_range(0, 5);
                case (kind)
                    0: budget = '0;
                    1: budget = BUDGET_FULL;
                    2: budget = 40'($urandom_range(0, 4000));
                    3: budget = 40'($urandom_range(0, 1 << 20));
                    default: budget = {8'($urandom()), 32'($urandom())};
                endcase
                if (phase == 1) budget = '0;
                if (phase == 2) budget = BUDGET_FULL;
                write_register(CFG_BUDGET0 + 3'(ln), budget);
            end
            cfg_wr_en <= 1'b0;

            if ($urandom_range(0, 1) == 1) begin
                r.func = 1'b1;
                r.layer = 6'($urandom());
                r.expert = 8'($urandom());
                r.bytes = $urandom();
                send_request(r);
                sent++;
            end
            while (sent < (phase + 1) * RANDOM_REQUESTS / PHASES) begin
                calm_tail = (sent >= CALM_FROM);
                r.func = ($urandom_range(0, 59) == 0);
                r.layer = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, 3));
                r.expert = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 15));
                kind = $urandom_range(0, 9);
                case (kind)
                    0: r.bytes = '0;
                    1: r.bytes = 32'hFFFF_FFFF;
                    2, 3, 4, 5: r.bytes = $urandom_range(0, 200);
                    6, 7: r.bytes = $urandom_range(0, 65535);
                    8: r.bytes = $urandom() >> $urandom_range(4, 16);
                    default: r.bytes = $urandom();
                endcase
                send_request(r);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
